FILE: design/mi3_pkg.sv
// Shared widths, types and cofactor index tables for the 3x3 matrix inverse unit.
package mi3_pkg;

    localparam int ELEMENT_BITS = 16;
    localparam int FIELD_W      = 16;
    localparam int ELEM_W       = (ELEMENT_BITS < FIELD_W) ? ELEMENT_BITS : FIELD_W;
    localparam int ELEM_SH      = FIELD_W - ELEM_W;

    localparam int N_ELEM   = 9;
    localparam int PROD_W   = 2 * FIELD_W;
    localparam int COF_W    = PROD_W + 1;
    localparam int DPROD_W  = FIELD_W + COF_W;
    localparam int DET_W    = DPROD_W + 2;
    localparam int DMAG_W   = DET_W - 1;
    localparam int THR_W    = 48;
    localparam int QSHIFT   = 28;
    localparam int NUM_W    = COF_W + QSHIFT;
    localparam int Q_W      = 32;
    localparam int CMP_W    = DMAG_W + Q_W;
    localparam int RES_W    = 32;
    localparam int COPY_SH  = 4;

    localparam int COF_LAT   = 6;
    localparam int DIV_STEPS = Q_W;
    localparam int LANE_LAT  = DIV_STEPS + 2;
    localparam int TOTAL_LAT = COF_LAT + LANE_LAT + 1;

    localparam logic [RES_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [RES_W-1:0] SAT_NEG = 32'h8000_0000;

    // Cofactor k is a[A]*a[B] - a[C]*a[D].
    localparam logic [3:0] CF_A [N_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam logic [3:0] CF_B [N_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam logic [3:0] CF_C [N_ELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam logic [3:0] CF_D [N_ELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    typedef logic [N_ELEM-1:0][FIELD_W-1:0] elems_t;

    typedef struct packed {
        elems_t                          elem;
        logic [N_ELEM-1:0][COF_W-1:0]    cmag;
        logic [N_ELEM-1:0]               qneg;
        logic [DMAG_W-1:0]               dmag;
        logic                            inv;
    } cof_t;

    function automatic logic signed [FIELD_W-1:0] sext_elem(input logic [FIELD_W-1:0] raw);
        logic signed [FIELD_W-1:0] t;
        t = $signed(raw << ELEM_SH);
        return t >>> ELEM_SH;
    endfunction

endpackage

FILE: design/matrix_inverse_3x3_unit.sv
// Top level of the 3x3 matrix inverse unit: cofactor pipeline, nine divider lanes, merge stage.
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_valid / s_ready    s_m00 .. s_m22, signed Q4.12
//  m_        out        m_valid / m_ready    m_r00 .. m_r22 Q16.16, m_invertible
//  cfg_      in         cfg_we               cfg_wdata, det_threshold Q12.36
//
// One request is accepted per cycle; each passes 41 register stages before its result is
// valid: six stages for cofactors and determinant, 34 in the one-bit-per-stage divider
// lanes, one to merge. Reset is synchronous on aresetn and clears valid state and sets the
// threshold to 1. The whole pipeline holds while a result waits and m_ready is low.
module matrix_inverse_3x3_unit import mi3_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [THR_W-1:0]      cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [FIELD_W-1:0] s_m00,
    input  logic signed [FIELD_W-1:0] s_m01,
    input  logic signed [FIELD_W-1:0] s_m02,
    input  logic signed [FIELD_W-1:0] s_m10,
    input  logic signed [FIELD_W-1:0] s_m11,
    input  logic signed [FIELD_W-1:0] s_m12,
    input  logic signed [FIELD_W-1:0] s_m20,
    input  logic signed [FIELD_W-1:0] s_m21,
    input  logic signed [FIELD_W-1:0] s_m22,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [RES_W-1:0] m_r00,
    output logic signed [RES_W-1:0] m_r01,
    output logic signed [RES_W-1:0] m_r02,
    output logic signed [RES_W-1:0] m_r10,
    output logic signed [RES_W-1:0] m_r11,
    output logic signed [RES_W-1:0] m_r12,
    output logic signed [RES_W-1:0] m_r20,
    output logic signed [RES_W-1:0] m_r21,
    output logic signed [RES_W-1:0] m_r22,
    output logic                  m_invertible
);

    logic [THR_W-1:0]     thr_reg;
    logic [TOTAL_LAT-1:0] vld_reg;
    logic                 en;
    elems_t               elem_in;
    cof_t                 cof;
    logic [RES_W-1:0]     quot [N_ELEM];
    elems_t               elem_dly_reg [LANE_LAT];
    logic                 inv_dly_reg [LANE_LAT];
    logic [RES_W-1:0]     res_reg [N_ELEM];
    logic                 inv_reg;

    assign en      = !vld_reg[TOTAL_LAT-1] || m_ready;
    assign s_ready = en;
    assign elem_in = {s_m22, s_m21, s_m20, s_m12, s_m11, s_m10, s_m02, s_m01, s_m00};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_W'(1);
            vld_reg <= '0;
        end else begin
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
            if (en) begin
                vld_reg <= {vld_reg[TOTAL_LAT-2:0], s_valid};
            end
        end
    end

    mi3_cofactor u_cof (
        .aclk          (aclk),
        .en            (en),
        .elem_in       (elem_in),
        .det_threshold (thr_reg),
        .cof_out       (cof)
    );

    for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
        mi3_div_lane u_lane (
            .aclk    (aclk),
            .en      (en),
            .num_mag (cof.cmag[k]),
            .neg     (cof.qneg[k]),
            .den_mag (cof.dmag),
            .quot    (quot[k])
        );
    end

    // Input copy and flag travel beside the lanes so the merge sees a matched set.
    always_ff @(posedge aclk) begin
        if (en) begin
            elem_dly_reg[0] <= cof.elem;
            inv_dly_reg[0]  <= cof.inv;
            for (int s = 1; s < LANE_LAT; s++) begin
                elem_dly_reg[s] <= elem_dly_reg[s-1];
                inv_dly_reg[s]  <= inv_dly_reg[s-1];
            end
            for (int k = 0; k < N_ELEM; k++) begin
                res_reg[k] <= inv_dly_reg[LANE_LAT-1] ? quot[k] :
                    RES_W'($signed({sext_elem(elem_dly_reg[LANE_LAT-1][k]),
                                    {COPY_SH{1'b0}}}));
            end
            inv_reg <= inv_dly_reg[LANE_LAT-1];
        end
    end

    assign m_valid      = vld_reg[TOTAL_LAT-1];
    assign m_r00        = res_reg[0];
    assign m_r01        = res_reg[1];
    assign m_r02        = res_reg[2];
    assign m_r10        = res_reg[3];
    assign m_r11        = res_reg[4];
    assign m_r12        = res_reg[5];
    assign m_r20        = res_reg[6];
    assign m_r21        = res_reg[7];
    assign m_r22        = res_reg[8];
    assign m_invertible = inv_reg;

endmodule

FILE: design/mi3_cofactor.sv
// Cofactor, determinant and singularity test pipeline for one matrix per cycle while en is high.
module mi3_cofactor import mi3_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  elems_t            elem_in,
    input  logic [THR_W-1:0]  det_threshold,
    output cof_t              cof_out
);

    logic signed [FIELD_W-1:0] a1_reg [N_ELEM];
    logic signed [FIELD_W-1:0] a2_reg [N_ELEM];
    logic signed [FIELD_W-1:0] a3_reg [N_ELEM];
    logic signed [FIELD_W-1:0] a4_reg [N_ELEM];
    logic signed [FIELD_W-1:0] a5_reg [N_ELEM];
    logic signed [PROD_W-1:0]  pp_reg [N_ELEM];
    logic signed [PROD_W-1:0]  pm_reg [N_ELEM];
    logic signed [COF_W-1:0]   c3_reg [N_ELEM];
    logic signed [COF_W-1:0]   c4_reg [N_ELEM];
    logic signed [DPROD_W-1:0] dp_reg [3];
    logic        [COF_W-1:0]   cmag5_reg [N_ELEM];
    logic                      cneg5_reg [N_ELEM];
    logic signed [DET_W-1:0]   det_reg;
    cof_t                      out_reg;
    cof_t                      out_next;
    logic signed [DET_W-1:0]   det_abs;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N_ELEM; k++) begin
                a1_reg[k] <= sext_elem(elem_in[k]);
                a2_reg[k] <= a1_reg[k];
                pp_reg[k] <= PROD_W'(a1_reg[CF_A[k]]) * PROD_W'(a1_reg[CF_B[k]]);
                pm_reg[k] <= PROD_W'(a1_reg[CF_C[k]]) * PROD_W'(a1_reg[CF_D[k]]);
                a3_reg[k] <= a2_reg[k];
                c3_reg[k] <= COF_W'(pp_reg[k]) - COF_W'(pm_reg[k]);
                a4_reg[k] <= a3_reg[k];
                c4_reg[k] <= c3_reg[k];
                a5_reg[k] <= a4_reg[k];
                cneg5_reg[k] <= c4_reg[k][COF_W-1];
                cmag5_reg[k] <= c4_reg[k][COF_W-1] ? COF_W'(-c4_reg[k]) : COF_W'(c4_reg[k]);
            end
            dp_reg[0] <= DPROD_W'(a3_reg[0]) * DPROD_W'(c3_reg[0]);
            dp_reg[1] <= DPROD_W'(a3_reg[1]) * DPROD_W'(c3_reg[3]);
            dp_reg[2] <= DPROD_W'(a3_reg[2]) * DPROD_W'(c3_reg[6]);
            det_reg   <= DET_W'(dp_reg[0]) + DET_W'(dp_reg[1]) + DET_W'(dp_reg[2]);
            out_reg   <= out_next;
        end
    end

    always_comb begin
        det_abs       = det_reg[DET_W-1] ? -det_reg : det_reg;
        out_next.dmag = det_abs[DMAG_W-1:0];
        out_next.inv  = {1'b0, det_abs[DMAG_W-1:0]} > DET_W'(det_threshold);
        for (int k = 0; k < N_ELEM; k++) begin
            out_next.elem[k] = a5_reg[k];
            out_next.cmag[k] = cmag5_reg[k];
            out_next.qneg[k] = cneg5_reg[k] ^ det_reg[DET_W-1];
        end
    end

    assign cof_out = out_reg;

endmodule

FILE: design/mi3_div_lane.sv
// Pipelined restoring divider lane: cofactor over determinant as rounded, saturated Q16.16.
module mi3_div_lane import mi3_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [COF_W-1:0]  num_mag,
    input  logic              neg,
    input  logic [DMAG_W-1:0] den_mag,
    output logic [RES_W-1:0]  quot
);

    logic [NUM_W-1:0]  rem_reg [DIV_STEPS+1];
    logic [DMAG_W-1:0] den_reg [DIV_STEPS+1];
    logic [Q_W-1:0]    quo_reg [DIV_STEPS+1];
    logic              neg_reg [DIV_STEPS+1];
    logic              ovf_reg [DIV_STEPS+1];
    logic [RES_W-1:0]  res_reg;
    logic [RES_W-1:0]  res_next;
    logic [NUM_W-1:0]  num;
    logic              rnd;
    logic [Q_W:0]      q_rnd;

    assign num = {num_mag, {QSHIFT{1'b0}}};

    // A quotient of 2^32 or more saturates regardless of rounding.
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num;
            den_reg[0] <= den_mag;
            quo_reg[0] <= '0;
            neg_reg[0] <= neg;
            ovf_reg[0] <= CMP_W'(num) >= {den_mag, {Q_W{1'b0}}};
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        localparam int SH = DIV_STEPS - k;
        logic [CMP_W-1:0] dsh;
        logic             ge;
        assign dsh = CMP_W'(den_reg[k-1]) << SH;
        assign ge  = CMP_W'(rem_reg[k-1]) >= dsh;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? NUM_W'(CMP_W'(rem_reg[k-1]) - dsh) : rem_reg[k-1];
                quo_reg[k] <= quo_reg[k-1] | (Q_W'(ge) << SH);
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    always_comb begin
        rnd   = {rem_reg[DIV_STEPS], 1'b0} >= (NUM_W+1)'(den_reg[DIV_STEPS]);
        q_rnd = (Q_W+1)'(quo_reg[DIV_STEPS]) + (Q_W+1)'(rnd);
        if (neg_reg[DIV_STEPS]) begin
            if (ovf_reg[DIV_STEPS] || q_rnd >= (Q_W+1)'(SAT_NEG)) begin
                res_next = SAT_NEG;
            end else begin
                res_next = RES_W'(-q_rnd);
            end
        end else begin
            if (ovf_reg[DIV_STEPS] || q_rnd > (Q_W+1)'(SAT_POS)) begin
                res_next = SAT_POS;
            end else begin
                res_next = RES_W'(q_rnd);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign quot = res_reg;

endmodule
